// ----- hw/rtl/apmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and widths for the alarm priority message queue.
// No dependencies; imported by every other file of the block except apmq_ram.
package apmq_pkg;

    // Fixed field widths of the item channels
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MSG_WIDTH   = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NORMAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALARM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECV   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALARM_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // take the item on the request channel and update state
        logic load;   // move the pending result into the response register
    } ctrl_cmd_t;

endpackage

// ----- hw/rtl/apmq_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: command and payload word with valid/ready handshake.
// Depends on apmq_pkg.
interface apmq_req_if
    import apmq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] msg_data;

    modport source (output valid, output cmd, output msg_data, input ready);
    modport sink   (input valid, input cmd, input msg_data, output ready);
endinterface

// ----- hw/rtl/apmq_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: one result item per request, valid/ready handshake.
// Depends on apmq_pkg.
interface apmq_rsp_if
    import apmq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_msg;
    logic                out_is_alarm;
    logic [ENTRY_W-1:0]  entry_count;
    logic                alarm_pending;

    modport source (output valid, output status, output out_msg, output out_is_alarm,
                    output entry_count, output alarm_pending, input ready);
    modport sink   (input valid, input status, input out_msg, input out_is_alarm,
                    input entry_count, input alarm_pending, output ready);
endinterface

// ----- hw/rtl/apmq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apmq_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/apmq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences accept, store read and result load; owns the handshakes.
// Depends on apmq_pkg.
module apmq_ctrl
    import apmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t cmd
);

    typedef enum logic {S_IDLE, S_FETCH} state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Result register is free when empty or being taken this cycle
    assign cmd.exec = req_valid && (state_reg == S_IDLE);
    assign cmd.load = (state_reg == S_FETCH) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (cmd.load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hw/rtl/apmq_dp.sv -----
`timescale 1ns / 1ps
// Datapath: store pointers, count, alarm slot, pending result and response register.
// Depends on apmq_pkg and apmq_ram.
module apmq_dp
    import apmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MSG_WIDTH   = DEF_MSG_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic [CMD_W-1:0]    req_cmd,
    input  logic [DATA_W-1:0]   req_data,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   out_msg,
    output logic                out_is_alarm,
    output logic [ENTRY_W-1:0]  entry_count,
    output logic                alarm_pending
);

    // Payloads never carry more than the channel word
    localparam int SW = (MSG_WIDTH > DATA_W) ? DATA_W : MSG_WIDTH;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = (CW + 1 > ENTRY_W) ? CW + 1 : ENTRY_W;

    typedef enum logic [1:0] {SRC_NONE, SRC_ALARM, SRC_STORE} msg_src_t;

    // Control state
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] ncount_reg, ncount_next;
    logic          alarm_valid_reg, alarm_valid_next;

    // Payload state
    logic [SW-1:0]       alarm_data_reg, alarm_data_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    msg_src_t            pend_src_reg, pend_src_next;
    logic [SW-1:0]       pend_msg_reg, pend_msg_next;
    logic [ENTRY_W-1:0]  pend_count_reg, pend_count_next;
    logic                pend_alarm_reg, pend_alarm_next;

    logic [STATUS_W-1:0] rsp_status_reg;
    logic [DATA_W-1:0]   rsp_msg_reg;
    logic                rsp_is_alarm_reg;
    logic [ENTRY_W-1:0]  rsp_count_reg;
    logic                rsp_alarm_reg;

    logic          ram_we;
    logic          ram_re;
    logic [SW-1:0] ram_rdata;
    logic [SW-1:0] data_in;
    logic          store_full;
    logic [EW-1:0] entry_sum;

    assign data_in    = req_data[SW-1:0];
    assign store_full = (ncount_reg == CW'(QUEUE_DEPTH));

    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        ncount_next      = ncount_reg;
        alarm_valid_next = alarm_valid_reg;
        alarm_data_next  = alarm_data_reg;
        pend_status_next = ST_OK;
        pend_src_next    = SRC_NONE;
        pend_msg_next    = '0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        if (cmd.exec)
        begin
            case (req_cmd)
                CMD_NORMAL:
                begin
                    if (store_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                      : wr_ptr_reg + 1'b1;
                        ncount_next = ncount_reg + 1'b1;
                    end
                end
                CMD_ALARM:
                begin
                    if (alarm_valid_reg)
                    begin
                        pend_status_next = ST_ALARM_BUSY;
                    end
                    else
                    begin
                        alarm_valid_next = 1'b1;
                        alarm_data_next  = data_in;
                    end
                end
                CMD_RECV:
                begin
                    // Alarm slot drains before the store
                    if (alarm_valid_reg)
                    begin
                        pend_src_next    = SRC_ALARM;
                        pend_msg_next    = alarm_data_reg;
                        alarm_valid_next = 1'b0;
                    end
                    else if (ncount_reg != '0)
                    begin
                        pend_src_next = SRC_STORE;
                        ram_re        = 1'b1;
                        rd_ptr_next   = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                        : rd_ptr_reg + 1'b1;
                        ncount_next   = ncount_reg - 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
        end
    end

    assign entry_sum       = EW'(ncount_next) + EW'(alarm_valid_next);
    assign pend_count_next = entry_sum[ENTRY_W-1:0];
    assign pend_alarm_next = alarm_valid_next;

    apmq_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (data_in),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            ncount_reg      <= '0;
            alarm_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            ncount_reg      <= ncount_next;
            alarm_valid_reg <= alarm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alarm_data_reg <= alarm_data_next;
        if (cmd.exec)
        begin
            pend_status_reg <= pend_status_next;
            pend_src_reg    <= pend_src_next;
            pend_msg_reg    <= pend_msg_next;
            pend_count_reg  <= pend_count_next;
            pend_alarm_reg  <= pend_alarm_next;
        end
        if (cmd.load)
        begin
            rsp_status_reg   <= pend_status_reg;
            rsp_msg_reg      <= (pend_src_reg == SRC_STORE) ? DATA_W'(ram_rdata)
                                : DATA_W'(pend_msg_reg);
            rsp_is_alarm_reg <= (pend_src_reg == SRC_ALARM);
            rsp_count_reg    <= pend_count_reg;
            rsp_alarm_reg    <= pend_alarm_reg;
        end
    end

    assign status        = rsp_status_reg;
    assign out_msg       = rsp_msg_reg;
    assign out_is_alarm  = rsp_is_alarm_reg;
    assign entry_count   = rsp_count_reg;
    assign alarm_pending = rsp_alarm_reg;

endmodule

// ----- hw/rtl/alarm_priority_message_queue_unit.sv -----
`timescale 1ns / 1ps
// Top level of the alarm priority message queue: controller plus datapath.
// Depends on apmq_pkg, apmq_req_if, apmq_rsp_if, apmq_ctrl, apmq_dp, apmq_ram.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  cmd[1:0], msg_data[31:0]
//   rsp      out  valid/ready  status[1:0], out_msg[31:0], out_is_alarm,
//                              entry_count[4:0], alarm_pending
//
// In S_IDLE the controller accepts an item: pointers, count and the alarm slot are
// updated and the store read is issued; S_FETCH then loads the RAM read data into the
// response register once it is free, and req.ready is high again back in S_IDLE.
// Reset clears pointers, count, alarm flag and controller; store contents are not reset.
// While rsp is stalled the result holds, one more item can be accepted, and it
// then waits in the controller until the response register frees up.
module alarm_priority_message_queue_unit
    import apmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MSG_WIDTH   = DEF_MSG_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    apmq_req_if.sink   req,
    apmq_rsp_if.source rsp
);

    ctrl_cmd_t ctrl_cmd;

    apmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (ctrl_cmd)
    );

    apmq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_WIDTH   (MSG_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .req_cmd       (req.cmd),
        .req_data      (req.msg_data),
        .status        (rsp.status),
        .out_msg       (rsp.out_msg),
        .out_is_alarm  (rsp.out_is_alarm),
        .entry_count   (rsp.entry_count),
        .alarm_pending (rsp.alarm_pending)
    );

endmodule

// ----- test/alarm_priority_message_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for alarm_priority_message_queue_unit: directed and random
// command streams, an in-bench queue predictor, field-by-field response checks.
// Depends on apmq_pkg, apmq_req_if, apmq_rsp_if and the block's RTL.
module alarm_priority_message_queue_unit_tb;
    import apmq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STORE_DEPTH  = DEF_QUEUE_DEPTH;
    localparam int PTR_W        = $clog2(STORE_DEPTH);
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1425;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
    } msg_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   out_msg;
        logic                out_is_alarm;
        logic [ENTRY_W-1:0]  entry_count;
        logic                alarm_pending;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    apmq_req_if req_ch ();
    apmq_rsp_if rsp_ch ();

    alarm_priority_message_queue_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    msg_cmd_t      cmd_q[$];
    queue_result_t result_q[$];

    // predictor state
    logic [DATA_W-1:0]  mq_store [STORE_DEPTH];
    logic [PTR_W-1:0]   mq_rd_ptr;
    logic [PTR_W-1:0]   mq_wr_ptr;
    logic [ENTRY_W-1:0] mq_count;
    logic               mq_alarm_valid;
    logic [DATA_W-1:0]  mq_alarm_word;

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_left;
    int mismatch_cnt;
    int idle_cycles;
    bit req_taken;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic queue_result_t msgq_apply(input msg_cmd_t it);
        queue_result_t r;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_NORMAL:
            begin
                if (mq_count >= STORE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    mq_store[mq_wr_ptr] = it.data;
                    mq_wr_ptr = mq_wr_ptr + 1'b1;
                    mq_count = mq_count + 1'b1;
                end
            end
            CMD_ALARM:
            begin
                if (mq_alarm_valid)
                begin
                    r.status = ST_ALARM_BUSY;
                end
                else
                begin
                    mq_alarm_word = it.data;
                    mq_alarm_valid = 1'b1;
                end
            end
            CMD_RECV:
            begin
                // the alarm slot always wins over the normal store
                if (mq_alarm_valid)
                begin
                    r.out_msg = mq_alarm_word;
                    r.out_is_alarm = 1'b1;
                    mq_alarm_valid = 1'b0;
                end
                else if (mq_count > 0)
                begin
                    r.out_msg = mq_store[mq_rd_ptr];
                    mq_rd_ptr = mq_rd_ptr + 1'b1;
                    mq_count = mq_count - 1'b1;
                end
                else
                begin
                    r.status = ST_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = mq_count + ENTRY_W'(mq_alarm_valid);
        r.alarm_pending = mq_alarm_valid;
        return r;
    endfunction

    function automatic msg_cmd_t random_cmd(input int mode);
        msg_cmd_t it;
        int roll;
        int n_lim;
        int a_lim;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:
            begin
                n_lim = 70;
                a_lim = 80;
            end
            MODE_DRAIN:
            begin
                n_lim = 15;
                a_lim = 25;
            end
            default:
            begin
                n_lim = 42;
                a_lim = 57;
            end
        endcase
        if (roll < n_lim)
            it.cmd = CMD_NORMAL;
        else if (roll < a_lim)
            it.cmd = CMD_ALARM;
        else if (roll < 97)
            it.cmd = CMD_RECV;
        else
            it.cmd = CMD_UNUSED;
        case ($urandom_range(15))
            0: it.data = '0;
            1: it.data = '1;
            default: it.data = $urandom;
        endcase
        return it;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
        msg_cmd_t it;
        it.cmd = cmd;
        it.data = data;
        cmd_q.push_back(it);
    endtask

    task automatic push_random(input int total);
        int done;
        int n;
        int mode;
        done = 0;
        while (done < total)
        begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            n = $urandom_range(8, 40);
            if (n > total - done)
                n = total - done;
            repeat (n)
                cmd_q.push_back(random_cmd(mode));
            done += n;
        end
    endtask

    // returns at a rising edge once nothing is queued, offered or outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_q.size() != 0 || req_ch.valid || result_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        if (mismatch_cnt < 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
        mismatch_cnt++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        msg_cmd_t it;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = cmd_q.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.cmd      <= it.cmd;
                req_ch.msg_data <= it.data;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready, with the long hold-off counted here
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            recv_hold_left = recv_hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor, predictor hookup and watchdog
    always @(posedge clk)
    begin
        msg_cmd_t      seen;
        queue_result_t want;
        bit            rsp_taken;
        if (rst_n)
        begin
            req_taken = req_ch.valid && req_ch.ready;
            rsp_taken = rsp_ch.valid && rsp_ch.ready;
            if (req_taken)
            begin
                seen.cmd = req_ch.cmd;
                seen.data = req_ch.msg_data;
                result_q.push_back(msgq_apply(seen));
            end
            if (rsp_taken)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("unexpected item", '0, rsp_ch.out_msg);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", DATA_W'(want.status),
                                        DATA_W'(rsp_ch.status));
                    if (rsp_ch.out_msg !== want.out_msg)
                        report_mismatch("out_msg", want.out_msg, rsp_ch.out_msg);
                    if (rsp_ch.out_is_alarm !== want.out_is_alarm)
                        report_mismatch("out_is_alarm", DATA_W'(want.out_is_alarm),
                                        DATA_W'(rsp_ch.out_is_alarm));
                    if (rsp_ch.entry_count !== want.entry_count)
                        report_mismatch("entry_count", DATA_W'(want.entry_count),
                                        DATA_W'(rsp_ch.entry_count));
                    if (rsp_ch.alarm_pending !== want.alarm_pending)
                        report_mismatch("alarm_pending", DATA_W'(want.alarm_pending),
                                        DATA_W'(rsp_ch.alarm_pending));
                end
            end
            if (req_taken || rsp_taken)
                idle_cycles = 0;
            else if (cmd_q.size() != 0 || result_q.size() != 0 || req_ch.valid)
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_NORMAL;
        req_ch.msg_data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 51;
        recv_hold_left = 0;
        mismatch_cnt = 0;
        idle_cycles = 0;
        req_taken = 0;
        mq_rd_ptr = '0;
        mq_wr_ptr = '0;
        mq_count = '0;
        mq_alarm_valid = 1'b0;
        mq_alarm_word = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // empty receive, unused command, fill to full, full reject,
        // alarm taken while full, second alarm, alarm delivered first
        push_cmd(CMD_RECV, 32'hFFFF_FFFF);
        push_cmd(CMD_UNUSED, 32'h1234_5678);
        for (i = 0; i < STORE_DEPTH; i++)
        begin
            if (i == 0)
                push_cmd(CMD_NORMAL, 32'h0000_0000);
            else if (i == 1)
                push_cmd(CMD_NORMAL, 32'hFFFF_FFFF);
            else
                push_cmd(CMD_NORMAL, $urandom);
        end
        push_cmd(CMD_NORMAL, 32'hDEAD_BEEF);
        push_cmd(CMD_ALARM, 32'hFFFF_FFFF);
        push_cmd(CMD_ALARM, 32'h0000_0000);
        push_cmd(CMD_RECV, 32'h0000_0000);
        push_cmd(CMD_RECV, 32'hFFFF_FFFF);
        wait_drained();

        // receiver holds off while a fill burst is offered
        recv_hold_left = HOLD_CYCLES;
        repeat (60)
            cmd_q.push_back(random_cmd(MODE_FILL));
        push_random(RANDOM_ITEMS / 3 - 60);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 25;
        push_random(RANDOM_ITEMS / 3);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && result_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/apmq_pkg.sv
hw/rtl/apmq_req_if.sv
hw/rtl/apmq_rsp_if.sv
hw/rtl/apmq_ram.sv
hw/rtl/apmq_ctrl.sv
hw/rtl/apmq_dp.sv
hw/rtl/alarm_priority_message_queue_unit.sv
test/alarm_priority_message_queue_unit_tb.sv
